>>> rtl/dtan_pkg.sv
package dtan_pkg;

  localparam int unsigned InWidth  = 96;
  localparam int unsigned OutWidth = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } dtan_state_t;

  typedef struct packed {
    logic load;
    logic step_sec;
    logic step_min;
    logic step_hour;
    logic step_year;
    logic step_month;
    logic load_out;
  } dtan_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } dtan_status_t;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Zero-based month; February grows to 29 days in leap years.
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (mon < 4'd12) begin
      len = MonthLen[mon];
    end
    if (mon == 4'd1 && leap) begin
      len = 5'd29;
    end
    return len;
  endfunction

endpackage

>>> rtl/dtan_ctrl.sv
module dtan_ctrl
  import dtan_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  dtan_status_t status,
  output dtan_cmd_t    cmd
);

  dtan_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEC;
        end
      end
      ST_SEC: begin
        cmd.step_sec = 1'b1;
        state_nxt    = ST_MIN;
      end
      ST_MIN: begin
        cmd.step_min = 1'b1;
        state_nxt    = ST_HOUR;
      end
      ST_HOUR: begin
        cmd.step_hour = 1'b1;
        state_nxt     = ST_YEAR;
      end
      ST_YEAR: begin
        if (status.year_fits) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.step_year = 1'b1;
        end
      end
      ST_MONTH: begin
        if (status.month_fits) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step_month = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SEC)
    else $error("accepted transaction did not start the time split");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished result not moved to the output register");
`endif

endmodule

>>> rtl/dtan_dp.sv
module dtan_dp
  import dtan_pkg::*;
(
  input  logic                clk,
  input  logic [InWidth-1:0]  in_tdata,
  input  dtan_cmd_t           cmd,
  output dtan_status_t        status,
  output logic [OutWidth-1:0] out_tdata
);

  logic [11:0] sec_r,  sec_nxt;
  logic [11:0] min_r,  min_nxt;
  logic [11:0] hour_r, hour_nxt;
  logic [12:0] day_r,  day_nxt;
  logic [8:0]  mraw_r, mraw_nxt;
  logic [3:0]  mon_r,  mon_nxt;
  logic [13:0] year_r, year_nxt;
  logic [5:0]  osec_r, osec_nxt;
  logic [5:0]  omin_r, omin_nxt;
  logic [4:0]  ohour_r, ohour_nxt;
  logic [OutWidth-1:0] out_r, out_nxt;

  // Divide by 60 through a reciprocal multiply and one correction step.
  logic [22:0] p60;
  logic [6:0]  q60_0, q60;
  logic [11:0] r60_0, r60;
  logic [23:0] p24;
  logic [7:0]  q24_0, q24;
  logic [11:0] r24_0, r24;
  logic [8:0]  m1;
  logic [17:0] p12;
  logic [6:0]  q12_0, q12;
  logic [8:0]  r12_0, r12;
  logic [11:0] div60_in;
  logic [8:0]  ylen;
  logic [4:0]  dim;
  logic        leap;

  assign div60_in = cmd.step_min ? min_r : sec_r;
  assign p60   = {11'd0, div60_in} * 23'd1092;
  assign q60_0 = p60[22:16];
  assign r60_0 = div60_in - 12'({5'd0, q60_0} * 12'd60);
  assign q60   = (r60_0 >= 12'd60) ? q60_0 + 7'd1 : q60_0;
  assign r60   = (r60_0 >= 12'd60) ? r60_0 - 12'd60 : r60_0;

  assign p24   = {12'd0, hour_r} * 24'd2731;
  assign q24_0 = p24[23:16];
  assign r24_0 = hour_r - 12'({4'd0, q24_0} * 12'd24);
  assign q24   = (r24_0 >= 12'd24) ? q24_0 + 8'd1 : q24_0;
  assign r24   = (r24_0 >= 12'd24) ? r24_0 - 12'd24 : r24_0;

  // Month zero counts as January.
  assign m1    = (mraw_r == 9'd0) ? 9'd0 : mraw_r - 9'd1;
  assign p12   = {9'd0, m1} * 18'd171;
  assign q12_0 = p12[17:11];
  assign r12_0 = m1 - 9'({2'd0, q12_0} * 9'd12);
  assign q12   = (r12_0 >= 9'd12) ? q12_0 + 7'd1 : q12_0;
  assign r12   = (r12_0 >= 9'd12) ? r12_0 - 9'd12 : r12_0;

  assign leap  = (year_r[1:0] == 2'b00);
  assign ylen  = leap ? 9'd366 : 9'd365;
  assign dim   = month_days(mon_r, leap);

  assign status.year_fits  = (day_r <= {4'd0, ylen});
  assign status.month_fits = (day_r <= {8'd0, dim});

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    mraw_nxt  = mraw_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    osec_nxt  = osec_r;
    omin_nxt  = omin_r;
    ohour_nxt = ohour_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      sec_nxt  = {2'd0, in_tdata[9:0]}   + {2'd0, in_tdata[39:30]};
      min_nxt  = {2'd0, in_tdata[19:10]} + {2'd0, in_tdata[49:40]};
      hour_nxt = {2'd0, in_tdata[29:20]} + {2'd0, in_tdata[59:50]};
      day_nxt  = {1'b0, in_tdata[71:60]};
      mraw_nxt = in_tdata[80:72];
      year_nxt = in_tdata[94:81];
    end
    if (cmd.step_sec) begin
      osec_nxt = r60[5:0];
      min_nxt  = min_r + {5'd0, q60};
      mon_nxt  = r12[3:0];
      year_nxt = year_r + {7'd0, q12};
    end
    if (cmd.step_min) begin
      omin_nxt = r60[5:0];
      hour_nxt = hour_r + {5'd0, q60};
    end
    if (cmd.step_hour) begin
      ohour_nxt = r24[4:0];
      day_nxt   = day_r + {5'd0, q24};
    end
    if (cmd.step_year) begin
      day_nxt  = day_r - {4'd0, ylen};
      year_nxt = year_r + 14'd1;
    end
    if (cmd.step_month) begin
      day_nxt = day_r - {8'd0, dim};
      if (mon_r == 4'd11) begin
        mon_nxt  = 4'd0;
        year_nxt = year_r + 14'd1;
      end else begin
        mon_nxt = mon_r + 4'd1;
      end
    end
    if (cmd.load_out) begin
      out_nxt = {year_r, mon_r + 4'd1, day_r[4:0], ohour_r, omin_r, osec_r};
    end
  end

  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hour_r  <= hour_nxt;
    day_r   <= day_nxt;
    mraw_r  <= mraw_nxt;
    mon_r   <= mon_nxt;
    year_r  <= year_nxt;
    osec_r  <= osec_nxt;
    omin_r  <= omin_nxt;
    ohour_r <= ohour_nxt;
    out_r   <= out_nxt;
  end

  assign out_tdata = out_r;

endmodule

>>> rtl/datetime_add_normalize_core.sv
// Adds a time of day to a start date and time and returns the normalized
// date and time, one result transaction per input transaction. Seconds,
// minutes and hours are summed field by field, then split through a
// divide-by-60, divide-by-60 and divide-by-24 step that carries whole
// days into the day count; month zero counts as January and surplus
// months carry into the year. Whole years (366 days when the year is
// divisible by 4, else 365) and then whole months are removed one per
// cycle; at most 11 whole years and at most 12 whole months come off the
// day count. One item is in flight at a time; the output register holds
// a finished result while the next transaction is accepted and worked on.
module datetime_add_normalize_core
  import dtan_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [9:0] start_seconds, [19:10] start_minutes, [29:20] start_hours,
  // [39:30] add_seconds, [49:40] add_minutes, [59:50] add_hours,
  // [71:60] start_day, [80:72] start_month, [94:81] start_year, [95] zero
  input  logic [InWidth-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [5:0] out_seconds, [11:6] out_minutes, [16:12] out_hours,
  // [21:17] out_day, [25:22] out_month, [39:26] out_year
  output logic [OutWidth-1:0] out_tdata
);

  dtan_cmd_t    cmd;
  dtan_status_t status;

  // Sequence the split, year and month steps and own the output valid.
  dtan_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold the working fields, the divide units and the result register.
  dtan_dp u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

>>> tb/sv/tb_datetime_add_normalize_core.sv
`timescale 1ns / 100ps

module tb_datetime_add_normalize_core;
  import dtan_pkg::*;

  // Run control: cycle budget, the receiver hold-off window and a stretch
  // where neither side idles.
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldStart  = 6000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned CalmStart  = 20000;
  localparam int unsigned CalmEnd    = 28000;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned RandItems  = 1800;
  localparam int unsigned DrainWait  = 40;

  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30,
                                             31, 31, 30, 31, 30, 31};

  // One input transaction, first field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic [13:0] start_year;
    logic [8:0]  start_month;
    logic [11:0] start_day;
    logic [9:0]  add_hours;
    logic [9:0]  add_minutes;
    logic [9:0]  add_seconds;
    logic [9:0]  start_hours;
    logic [9:0]  start_minutes;
    logic [9:0]  start_seconds;
  } stamp_in_t;

  // One result transaction, first field in the lowest bits.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } stamp_out_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InWidth-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutWidth-1:0] out_tdata;

  stamp_in_t   pending_stamps[$];
  stamp_out_t  expected_sums[$];
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        calm;

  datetime_add_normalize_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Neither side idles inside this window.
  assign calm = (cycle_count >= CalmStart) && (cycle_count < CalmEnd);

  // Add the time fields, split the total seconds into a clock time and a
  // day carry, then strip whole years and whole months off the day count.
  function automatic stamp_out_t normalize_datetime(stamp_in_t item);
    int unsigned secs, mins, hrs, total, day, mon, year, span;
    stamp_out_t sum;
    secs  = item.start_seconds + item.add_seconds;
    mins  = item.start_minutes + item.add_minutes;
    hrs   = item.start_hours + item.add_hours;
    total = secs + mins * 60 + hrs * 3600;
    sum.seconds = 6'(total % 60);
    total = total / 60;
    sum.minutes = 6'(total % 60);
    total = total / 60;
    sum.hours = 5'(total % 24);
    day = item.start_day + total / 24;
    // Month zero reads as January; surplus months carry into the year.
    mon = item.start_month;
    if (mon == 0) begin
      mon = 1;
    end
    mon  = mon - 1;
    year = item.start_year + mon / 12;
    mon  = mon % 12;
    // Year length follows the current year, wherever the month stands.
    forever begin
      span = (year % 4 == 0) ? 366 : 365;
      if (day <= span) begin
        break;
      end
      day  = day - span;
      year = year + 1;
    end
    forever begin
      span = (mon == 1 && year % 4 == 0) ? 29 : MonthDays[mon];
      if (day <= span) begin
        break;
      end
      day = day - span;
      mon = mon + 1;
      if (mon == 12) begin
        mon  = 0;
        year = year + 1;
      end
    end
    sum.day   = 5'(day);
    sum.month = 4'(mon + 1);
    sum.year  = 14'(year);
    return sum;
  endfunction

  function automatic stamp_in_t make_stamp(int unsigned ss, int unsigned sm, int unsigned sh,
                                           int unsigned as, int unsigned am, int unsigned ah,
                                           int unsigned day, int unsigned mon,
                                           int unsigned year);
    stamp_in_t item;
    item.pad           = 1'b0;
    item.start_seconds = 10'(ss);
    item.start_minutes = 10'(sm);
    item.start_hours   = 10'(sh);
    item.add_seconds   = 10'(as);
    item.add_minutes   = 10'(am);
    item.add_hours     = 10'(ah);
    item.start_day     = 12'(day);
    item.start_month   = 9'(mon);
    item.start_year    = 14'(year);
    return item;
  endfunction

  // Pick a field value at an end of its range or anywhere in it.
  function automatic int unsigned pick_edge(int unsigned top);
    case ($urandom_range(3))
      0: return 0;
      1: return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  // Mix full-range noise, calendar-like dates with random offsets, and
  // items pinned to field extremes.
  function automatic stamp_in_t random_stamp();
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode < 4) begin
      return make_stamp($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                        $urandom_range(4095), $urandom_range(511), $urandom_range(16383));
    end else if (mode < 9) begin
      return make_stamp($urandom_range(59), $urandom_range(59), $urandom_range(23),
                        $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                        ($urandom_range(1)) ? $urandom_range(1, 31) : $urandom_range(400),
                        $urandom_range(1, 12), $urandom_range(16383));
    end
    return make_stamp(pick_edge(1023), pick_edge(1023), pick_edge(1023),
                      pick_edge(1023), pick_edge(1023), pick_edge(1023),
                      pick_edge(4095), pick_edge(511), pick_edge(16383));
  endfunction

  task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    error_count++;
  endtask

  // Sender: hold a transaction until it is taken, then advance to the next
  // pending item or idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_stamps.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_stamps.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and once hold off for a long stretch so the
  // block fills up and drops in_tready while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (cycle_count == HoldStart) begin
      out_tready <= 1'b0;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: record the expected sum of every accepted input transaction,
  // and check every accepted result against the oldest one outstanding.
  always @(posedge clk) begin : monitor
    stamp_out_t want;
    stamp_out_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_sums.push_back(normalize_datetime(stamp_in_t'(in_tdata)));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        got = stamp_out_t'(out_tdata);
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected result, year field", got.year, 0);
        end else begin
          want = expected_sums.pop_front();
          if (got.seconds !== want.seconds) report_mismatch("seconds", got.seconds, want.seconds);
          if (got.minutes !== want.minutes) report_mismatch("minutes", got.minutes, want.minutes);
          if (got.hours !== want.hours) report_mismatch("hours", got.hours, want.hours);
          if (got.day !== want.day) report_mismatch("day", got.day, want.day);
          if (got.month !== want.month) report_mismatch("month", got.month, want.month);
          if (got.year !== want.year) report_mismatch("year", got.year, want.year);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("datetime_add_normalize_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned total_items;
    // Directed: all-zero input with month zero and day zero, all fields at
    // their maximum, rollover at the end of a year, leap and non-leap
    // February, day zero with and without a day carry, year-length edges,
    // month surplus and year wrap.
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_stamps.push_back(make_stamp(1023, 1023, 1023, 1023, 1023, 1023, 4095, 511, 16383));
    pending_stamps.push_back(make_stamp(59, 59, 23, 1, 0, 0, 31, 12, 1999));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 29, 2, 2024));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 29, 2, 2023));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 29, 2, 1900));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 24, 0, 5, 2023));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 48, 0, 3, 2023));
    pending_stamps.push_back(make_stamp(30, 20, 10, 0, 0, 0, 0, 7, 2001));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 366, 1, 2020));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 367, 1, 2020));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 365, 1, 2021));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 366, 1, 2021));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 366, 12, 2023));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 60, 12, 2023));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 1, 13, 2023));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 15, 256, 0));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 4095, 1, 0));
    pending_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0, 367, 1, 16383));
    pending_stamps.push_back(make_stamp(1023, 0, 0, 0, 0, 0, 1, 1, 2000));
    pending_stamps.push_back(make_stamp(0, 1023, 0, 0, 0, 0, 1, 1, 2000));
    pending_stamps.push_back(make_stamp(0, 0, 1023, 0, 0, 0, 1, 1, 2000));
    pending_stamps.push_back(make_stamp(0, 0, 0, 1023, 1023, 1023, 28, 2, 2023));
    repeat (RandItems) pending_stamps.push_back(random_stamp());
    total_items = pending_stamps.size();

    // Reset once, then release on a rising edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every item taken and every result checked, then a short quiet
    // spell to catch any stray result.
    while (accepted_count < total_items || expected_sums.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (error_count == 0) begin
      $display("datetime_add_normalize_core regression: pass");
    end else begin
      $display("datetime_add_normalize_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dtan_pkg.sv
rtl/dtan_ctrl.sv
rtl/dtan_dp.sv
rtl/datetime_add_normalize_core.sv
tb/sv/tb_datetime_add_normalize_core.sv
